/* rtl/qvr_pkg.sv */
// Package for the quaternion vector rotator: widths, constants and shared types.
package qvr_pkg;

	localparam int COORD_WIDTH     = 18;
	localparam int QUAT_FRAC_BITS  = 15;
	localparam int QUAT_WIDTH      = 16;
	localparam int CFG_INDEX_WIDTH = 2;

	// First product p * conj(q): one coordinate times one quaternion part.
	localparam int PROD1_WIDTH = COORD_WIDTH + QUAT_WIDTH;
	// Three products summed.
	localparam int SUM1_WIDTH  = PROD1_WIDTH + 2;

	// Reduce the intermediate quaternion for very wide coordinates.
	localparam int MID_SHIFT     = (COORD_WIDTH > 28) ? COORD_WIDTH - 28 : 0;
	localparam int MID_HALF_POS  = (MID_SHIFT > 0) ? MID_SHIFT - 1 : 0;
	localparam int T_ROUND_WIDTH = SUM1_WIDTH + 1;
	localparam int T_WIDTH       = T_ROUND_WIDTH - MID_SHIFT;
	localparam logic signed [T_ROUND_WIDTH-1:0] MID_HALF =
		(MID_SHIFT > 0) ? (T_ROUND_WIDTH'(1) << MID_HALF_POS) : '0;

	// Second product q * t and its four-term sum.
	localparam int PROD2_WIDTH = QUAT_WIDTH + T_WIDTH;
	localparam int SUM2_WIDTH  = PROD2_WIDTH + 2;

	// Final scaling back to the coordinate format.
	localparam int OUT_SHIFT     = 2 * QUAT_FRAC_BITS - MID_SHIFT;
	localparam int R_ROUND_WIDTH =
		((SUM2_WIDTH > OUT_SHIFT + COORD_WIDTH) ? SUM2_WIDTH : OUT_SHIFT + COORD_WIDTH) + 1;
	localparam logic signed [R_ROUND_WIDTH-1:0] OUT_HALF = R_ROUND_WIDTH'(1) << (OUT_SHIFT - 1);

	localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	localparam logic signed [QUAT_WIDTH-1:0] QUAT_W_RESET = 16'sh7FFF;
	localparam logic signed [QUAT_WIDTH-1:0] QUAT_V_RESET = '0;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_QUAT_W = 2'd0,
		REG_QUAT_X = 2'd1,
		REG_QUAT_Y = 2'd2,
		REG_QUAT_Z = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic signed [QUAT_WIDTH-1:0] w;
		logic signed [QUAT_WIDTH-1:0] x;
		logic signed [QUAT_WIDTH-1:0] y;
		logic signed [QUAT_WIDTH-1:0] z;
	} quat_t;

	// Intermediate quaternion t = p * conj(q).
	typedef struct packed {
		logic signed [T_WIDTH-1:0] w;
		logic signed [T_WIDTH-1:0] x;
		logic signed [T_WIDTH-1:0] y;
		logic signed [T_WIDTH-1:0] z;
	} tquat_t;

endpackage

/* rtl/qvr_if.sv */
// Channel interfaces of the quaternion vector rotator: vertex in, vertex out, register write.
interface vec_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [qvr_pkg::COORD_WIDTH-1:0] vec_x;
	logic signed [qvr_pkg::COORD_WIDTH-1:0] vec_y;
	logic signed [qvr_pkg::COORD_WIDTH-1:0] vec_z;

	modport source (output valid, output vec_x, output vec_y, output vec_z, input ready);
	modport sink (input valid, input vec_x, input vec_y, input vec_z, output ready);
endinterface

interface rot_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [qvr_pkg::COORD_WIDTH-1:0] rot_x;
	logic signed [qvr_pkg::COORD_WIDTH-1:0] rot_y;
	logic signed [qvr_pkg::COORD_WIDTH-1:0] rot_z;

	modport source (output valid, output rot_x, output rot_y, output rot_z, input ready);
	modport sink (input valid, input rot_x, input rot_y, input rot_z, output ready);
endinterface

interface cfg_if;
	logic                                       valid;
	logic                                       ready;
	logic [qvr_pkg::CFG_INDEX_WIDTH-1:0]        index;
	logic [qvr_pkg::QUAT_WIDTH-1:0]             data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/qvr_regs.sv */
// Configuration registers holding the rotation quaternion.
module qvr_regs (
	input  logic           clk,
	input  logic           arst_n,
	cfg_if.sink            cfg,
	output qvr_pkg::quat_t quat
);

	qvr_pkg::quat_t quat_q;

	assign cfg.ready = 1'b1;
	assign quat      = quat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quat_q.w <= qvr_pkg::QUAT_W_RESET;
			quat_q.x <= qvr_pkg::QUAT_V_RESET;
			quat_q.y <= qvr_pkg::QUAT_V_RESET;
			quat_q.z <= qvr_pkg::QUAT_V_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (qvr_pkg::cfg_reg_t'(cfg.index))
				qvr_pkg::REG_QUAT_W: quat_q.w <= cfg.data;
				qvr_pkg::REG_QUAT_X: quat_q.x <= cfg.data;
				qvr_pkg::REG_QUAT_Y: quat_q.y <= cfg.data;
				qvr_pkg::REG_QUAT_Z: quat_q.z <= cfg.data;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_write_w: assert property (@(posedge clk) disable iff (!arst_n)
		cfg.valid && (cfg.index == qvr_pkg::REG_QUAT_W) |=> quat_q.w == $past(cfg.data))
		else $error("quat_w write not taken");
	a_hold_quat: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg.valid |=> $stable(quat_q))
		else $error("quaternion changed without a write");
`endif

endmodule

/* rtl/qvr_left.sv */
// Stages 1-2: intermediate quaternion t = (0, v) * conj(q).
module qvr_left (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  qvr_pkg::quat_t                         quat,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [qvr_pkg::COORD_WIDTH-1:0] vx,
	input  logic signed [qvr_pkg::COORD_WIDTH-1:0] vy,
	input  logic signed [qvr_pkg::COORD_WIDTH-1:0] vz,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output qvr_pkg::tquat_t                        t
);

	localparam int PW = qvr_pkg::PROD1_WIDTH;
	localparam int SW = qvr_pkg::SUM1_WIDTH;
	localparam int RW = qvr_pkg::T_ROUND_WIDTH;
	localparam int TW = qvr_pkg::T_WIDTH;

	logic signed [qvr_pkg::QUAT_WIDTH-1:0] qw, qx, qy, qz;
	logic signed [PW-1:0] vxw_s1, vxx_s1, vxy_s1, vxz_s1;
	logic signed [PW-1:0] vyw_s1, vyx_s1, vyy_s1, vyz_s1;
	logic signed [PW-1:0] vzw_s1, vzx_s1, vzy_s1, vzz_s1;
	logic signed [SW-1:0] sum_w, sum_x, sum_y, sum_z;
	logic signed [RW-1:0] rnd_w, rnd_x, rnd_y, rnd_z;
	qvr_pkg::tquat_t      t_s2;
	logic                 v_s1, v_s2;
	logic                 adv_s1, adv_s2;

	assign qw = quat.w;
	assign qx = quat.x;
	assign qy = quat.y;
	assign qz = quat.z;

	// A stage advances when it is empty or the next one takes its item.
	assign adv_s2    = !v_s2 || out_ready;
	assign adv_s1    = !v_s1 || adv_s2;
	assign in_ready  = adv_s1;
	assign out_valid = v_s2;
	assign t         = t_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= in_valid;
			if (adv_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			vxw_s1 <= vx * qw;
			vxx_s1 <= vx * qx;
			vxy_s1 <= vx * qy;
			vxz_s1 <= vx * qz;
			vyw_s1 <= vy * qw;
			vyx_s1 <= vy * qx;
			vyy_s1 <= vy * qy;
			vyz_s1 <= vy * qz;
			vzw_s1 <= vz * qw;
			vzx_s1 <= vz * qx;
			vzy_s1 <= vz * qy;
			vzz_s1 <= vz * qz;
		end
	end

	always_comb begin
		sum_w = SW'(vxx_s1) + SW'(vyy_s1) + SW'(vzz_s1);
		sum_x = SW'(vxw_s1) - SW'(vyz_s1) + SW'(vzy_s1);
		sum_y = SW'(vxz_s1) + SW'(vyw_s1) - SW'(vzx_s1);
		sum_z = SW'(vyx_s1) - SW'(vxy_s1) + SW'(vzw_s1);
		// Round half up before the optional reduction.
		rnd_w = RW'(sum_w) + qvr_pkg::MID_HALF;
		rnd_x = RW'(sum_x) + qvr_pkg::MID_HALF;
		rnd_y = RW'(sum_y) + qvr_pkg::MID_HALF;
		rnd_z = RW'(sum_z) + qvr_pkg::MID_HALF;
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			t_s2.w <= TW'(rnd_w >>> qvr_pkg::MID_SHIFT);
			t_s2.x <= TW'(rnd_x >>> qvr_pkg::MID_SHIFT);
			t_s2.y <= TW'(rnd_y >>> qvr_pkg::MID_SHIFT);
			t_s2.z <= TW'(rnd_z >>> qvr_pkg::MID_SHIFT);
		end
	end

`ifndef SYNTHESIS
	a_enter_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s1)
		else $error("accepted item missing from stage 1");
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !adv_s2 |=> v_s1 && $stable(vxw_s1) && $stable(vzz_s1))
		else $error("stalled stage 1 item lost or changed");
`endif

endmodule

/* rtl/qvr_right.sv */
// Stages 3-5: vector part of q * t, scaled back, rounded and saturated.
module qvr_right (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  qvr_pkg::quat_t                         quat,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  qvr_pkg::tquat_t                        t,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [qvr_pkg::COORD_WIDTH-1:0] rx,
	output logic signed [qvr_pkg::COORD_WIDTH-1:0] ry,
	output logic signed [qvr_pkg::COORD_WIDTH-1:0] rz
);

	localparam int CW = qvr_pkg::COORD_WIDTH;
	localparam int PW = qvr_pkg::PROD2_WIDTH;
	localparam int SW = qvr_pkg::SUM2_WIDTH;
	localparam int RW = qvr_pkg::R_ROUND_WIDTH;
	localparam int TW = qvr_pkg::T_WIDTH;

	function automatic logic signed [CW-1:0] round_sat(input logic signed [SW-1:0] v);
		logic signed [RW-1:0] rnd;
		logic signed [RW-1:0] sh;
		logic [RW-CW:0]       upper;
		rnd   = RW'(v) + qvr_pkg::OUT_HALF;
		sh    = rnd >>> qvr_pkg::OUT_SHIFT;
		upper = sh[RW-1:CW-1];
		if ((&upper) || !(|upper)) return sh[CW-1:0];
		else if (sh[RW-1]) return qvr_pkg::COORD_MIN;
		else return qvr_pkg::COORD_MAX;
	endfunction

	logic signed [qvr_pkg::QUAT_WIDTH-1:0] qw, qx, qy, qz;
	logic signed [TW-1:0] tw, tx, ty, tz;
	logic signed [PW-1:0] wtx_s3, xtw_s3, ytz_s3, zty_s3;
	logic signed [PW-1:0] wty_s3, xtz_s3, ytw_s3, ztx_s3;
	logic signed [PW-1:0] wtz_s3, xty_s3, ytx_s3, ztw_s3;
	logic signed [SW-1:0] sx_s4, sy_s4, sz_s4;
	logic signed [CW-1:0] rx_s5, ry_s5, rz_s5;
	logic                 v_s3, v_s4, v_s5;
	logic                 adv_s3, adv_s4, adv_s5;

	assign qw = quat.w;
	assign qx = quat.x;
	assign qy = quat.y;
	assign qz = quat.z;
	assign tw = t.w;
	assign tx = t.x;
	assign ty = t.y;
	assign tz = t.z;

	assign adv_s5    = !v_s5 || out_ready;
	assign adv_s4    = !v_s4 || adv_s5;
	assign adv_s3    = !v_s3 || adv_s4;
	assign in_ready  = adv_s3;
	assign out_valid = v_s5;
	assign rx        = rx_s5;
	assign ry        = ry_s5;
	assign rz        = rz_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (adv_s3) v_s3 <= in_valid;
			if (adv_s4) v_s4 <= v_s3;
			if (adv_s5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3 && in_valid) begin
			wtx_s3 <= qw * tx;
			xtw_s3 <= qx * tw;
			ytz_s3 <= qy * tz;
			zty_s3 <= qz * ty;
			wty_s3 <= qw * ty;
			xtz_s3 <= qx * tz;
			ytw_s3 <= qy * tw;
			ztx_s3 <= qz * tx;
			wtz_s3 <= qw * tz;
			xty_s3 <= qx * ty;
			ytx_s3 <= qy * tx;
			ztw_s3 <= qz * tw;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s4 && v_s3) begin
			sx_s4 <= SW'(wtx_s3) + SW'(xtw_s3) + SW'(ytz_s3) - SW'(zty_s3);
			sy_s4 <= SW'(wty_s3) - SW'(xtz_s3) + SW'(ytw_s3) + SW'(ztx_s3);
			sz_s4 <= SW'(wtz_s3) + SW'(xty_s3) - SW'(ytx_s3) + SW'(ztw_s3);
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s5 && v_s4) begin
			rx_s5 <= round_sat(sx_s4);
			ry_s5 <= round_sat(sy_s4);
			rz_s5 <= round_sat(sz_s4);
		end
	end

`ifndef SYNTHESIS
	a_enter_s3: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s3)
		else $error("accepted item missing from stage 3");
	a_move_s5: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && adv_s4 |=> v_s5)
		else $error("item lost between stage 4 and output");
`endif

endmodule

/* rtl/quaternion_vector_rotator.sv */
// Top level of the quaternion vector rotator.
// Rotates each vertex v by the configured quaternion q as q * (0, v) * conj(q) and returns
// the vector part, rounded half up and saturated to the coordinate range. Coordinates are
// 18-bit signed fixed point; quaternion parts are 16-bit signed Q1.15 and are taken as unit
// length without renormalizing, so a non-unit q scales the result by |q|^2. The reset value
// (32767, 0, 0, 0) is just below identity and shrinks a vertex by (32767/32768)^2.
// Throughput is one item per clock while the result side keeps its ready high.
// The five register stages are: the twelve coordinate-by-quaternion products, their sums
// into t, the twelve quaternion-by-t products, the three four-term sums, and the final
// rounding with saturation, which also serves as the output register. Each stage holds its
// own item when the next one is full, so bubbles close up and input is taken while a result
// waits. Write the quaternion registers only while no item is in flight; writes are taken
// without stalling, and an index selects w, x, y or z in that order.
module quaternion_vector_rotator (
	input  logic  clk,
	input  logic  arst_n,
	vec_if.sink   vec,
	rot_if.source rot,
	cfg_if.sink   cfg
);

	qvr_pkg::quat_t  quat;
	qvr_pkg::tquat_t t;
	logic            t_valid;
	logic            t_ready;

	// Hold the rotation quaternion.
	qvr_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.quat   (quat)
	);

	// Form t = p * conj(q) in stages 1 and 2.
	qvr_left u_left (
		.clk       (clk),
		.arst_n    (arst_n),
		.quat      (quat),
		.in_valid  (vec.valid),
		.in_ready  (vec.ready),
		.vx        (vec.vec_x),
		.vy        (vec.vec_y),
		.vz        (vec.vec_z),
		.out_valid (t_valid),
		.out_ready (t_ready),
		.t         (t)
	);

	// Form the vector part of q * t and scale it back in stages 3 to 5.
	qvr_right u_right (
		.clk       (clk),
		.arst_n    (arst_n),
		.quat      (quat),
		.in_valid  (t_valid),
		.in_ready  (t_ready),
		.t         (t),
		.out_valid (rot.valid),
		.out_ready (rot.ready),
		.rx        (rot.rot_x),
		.ry        (rot.rot_y),
		.rz        (rot.rot_z)
	);

endmodule

/* dv/tb_quaternion_vector_rotator.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the quaternion vector rotator: directed and random vertices under stalls.
module tb_quaternion_vector_rotator;

	localparam int COORD_WIDTH    = qvr_pkg::COORD_WIDTH;
	localparam int QUAT_WIDTH     = qvr_pkg::QUAT_WIDTH;
	localparam int QUAT_FRAC_BITS = qvr_pkg::QUAT_FRAC_BITS;

	typedef qvr_pkg::quat_t    quat_t;
	typedef qvr_pkg::cfg_reg_t cfg_reg_t;

	// Intermediate reduction and final scaling, in the block's own fixed-point terms.
	localparam int T_REDUCE     = (COORD_WIDTH > 28) ? COORD_WIDTH - 28 : 0;
	localparam int R_SCALE      = 2 * QUAT_FRAC_BITS - T_REDUCE;
	localparam int PIPE_LATENCY = 5;
	localparam int DRAIN_CYCLES = 4 * PIPE_LATENCY;
	localparam int HOLD_CYCLES  = 80;
	localparam longint CYCLE_LIMIT = 400000;

	localparam logic signed [COORD_WIDTH-1:0] C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [COORD_WIDTH-1:0] C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
	localparam logic signed [QUAT_WIDTH-1:0]  Q_MAX = {1'b0, {(QUAT_WIDTH-1){1'b1}}};
	localparam logic signed [QUAT_WIDTH-1:0]  Q_MIN = {1'b1, {(QUAT_WIDTH-1){1'b0}}};

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] x;
		logic signed [COORD_WIDTH-1:0] y;
		logic signed [COORD_WIDTH-1:0] z;
	} vertex_t;

	// How the result side paces its ready.
	typedef enum {
		SINK_ALWAYS,
		SINK_RANDOM,
		SINK_PATTERN,
		SINK_SPARSE
	} sink_mode_t;

	logic clk;
	logic arst_n;

	vec_if vec_ch ();
	rot_if rot_ch ();
	cfg_if cfg_ch ();

	quaternion_vector_rotator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.vec    (vec_ch),
		.rot    (rot_ch),
		.cfg    (cfg_ch)
	);

	// Quaternion as the block holds it, updated on every accepted register write.
	quat_t      cur_quat;
	// Rotated vertices still owed by the block, oldest first.
	vertex_t    pending_rotations[$];
	int         mismatch_count = 0;
	longint     cycle_count = 0;

	// Sender pacing: bursts of back-to-back items, then a random gap.
	int         burst_left;
	bit         gaps_on;

	// Receiver pacing, plus a long hold-off that a test can request.
	sink_mode_t rx_mode = SINK_ALWAYS;
	int         rx_left = 50;
	logic [7:0] rx_mask = 8'hA5;
	int         hold_req = 0;
	int         hold_seen = 0;
	int         hold_left = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Abort a run that hangs.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Prediction
	// ---------------------------------------------------------------------

	// Divide by 2^s, rounding half toward plus infinity.
	function automatic longint round_half_up(longint v, int s);
		if (s <= 0)
			return v;
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic logic signed [COORD_WIDTH-1:0] clamp_coord(longint v);
		if (v > longint'(C_MAX))
			return C_MAX;
		if (v < longint'(C_MIN))
			return C_MIN;
		return v[COORD_WIDTH-1:0];
	endfunction

	// r = q * ((0, v) * conj(q)), vector part, scaled back and saturated.
	function automatic vertex_t rotate_vertex(quat_t q, vertex_t v);
		longint qw, qx, qy, qz, px, py, pz;
		longint tw, tx, ty, tz, rx, ry, rz;
		vertex_t res;
		qw = $signed(q.w);
		qx = $signed(q.x);
		qy = $signed(q.y);
		qz = $signed(q.z);
		px = $signed(v.x);
		py = $signed(v.y);
		pz = $signed(v.z);
		// t = (0, v) * (w, -x, -y, -z), exact
		tw = px * qx + py * qy + pz * qz;
		tx = px * qw - py * qz + pz * qy;
		ty = px * qz + py * qw - pz * qx;
		tz = py * qx - px * qy + pz * qw;
		tw = round_half_up(tw, T_REDUCE);
		tx = round_half_up(tx, T_REDUCE);
		ty = round_half_up(ty, T_REDUCE);
		tz = round_half_up(tz, T_REDUCE);
		// r = q * t, scalar part is not needed
		rx = qw * tx + qx * tw + qy * tz - qz * ty;
		ry = qw * ty - qx * tz + qy * tw + qz * tx;
		rz = qw * tz + qx * ty - qy * tx + qz * tw;
		res.x = clamp_coord(round_half_up(rx, R_SCALE));
		res.y = clamp_coord(round_half_up(ry, R_SCALE));
		res.z = clamp_coord(round_half_up(rz, R_SCALE));
		return res;
	endfunction

	// ---------------------------------------------------------------------
	// Result checking
	// ---------------------------------------------------------------------

	task automatic check_rotation(vertex_t got);
		vertex_t want;
		if (pending_rotations.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("unexpected rotated vertex (%0d, %0d, %0d) at cycle %0d",
					got.x, got.y, got.z, cycle_count);
			return;
		end
		want = pending_rotations.pop_front();
		if (got.x !== want.x || got.y !== want.y || got.z !== want.z) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("rotation mismatch at cycle %0d: expected (%0d, %0d, %0d), got (%0d, %0d, %0d)",
					cycle_count, want.x, want.y, want.z, got.x, got.y, got.z);
		end
	endtask

	// Sample the result handshake as it stood just before the edge.
	always @(posedge clk) begin
		if (arst_n && rot_ch.valid === 1'b1 && rot_ch.ready === 1'b1)
			check_rotation({rot_ch.rot_x, rot_ch.rot_y, rot_ch.rot_z});
	end

	// Receiver: a long hold-off when asked, otherwise a pacing mode that changes now and then.
	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			rot_ch.ready <= 1'b0;
			hold_left--;
		end else begin
			case (rx_mode)
				SINK_ALWAYS:  rot_ch.ready <= 1'b1;
				SINK_RANDOM:  rot_ch.ready <= ($urandom_range(0, 3) != 0);
				SINK_PATTERN: begin
					rot_ch.ready <= rx_mask[0];
					rx_mask = {rx_mask[0], rx_mask[7:1]};
				end
				default:      rot_ch.ready <= ($urandom_range(0, 3) == 0);
			endcase
			if (rx_left > 0) begin
				rx_left--;
			end else begin
				rx_mode = sink_mode_t'($urandom_range(0, 3));
				rx_left = int'($urandom_range(20, 300));
				rx_mask = 8'($urandom_range(1, 255));
			end
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------------

	// Hold one vertex on the input until it is taken, then record its rotation.
	task automatic send_vertex(vertex_t v);
		int gap;
		vec_ch.valid <= 1'b1;
		vec_ch.vec_x <= v.x;
		vec_ch.vec_y <= v.y;
		vec_ch.vec_z <= v.z;
		do
			@(posedge clk);
		while (vec_ch.ready !== 1'b1);
		pending_rotations = {pending_rotations, rotate_vertex(cur_quat, v)};
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			// End of a burst: drop valid for a while unless idling is off.
			burst_left = $urandom_range(0, 24);
			gap = gaps_on ? $urandom_range(1, 6) : 0;
			if (gap > 0) begin
				vec_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Drop valid and wait until every item has come back out.
	task automatic wait_idle();
		vec_ch.valid <= 1'b0;
		while (pending_rotations.size() != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY) @(posedge clk);
	endtask

	function automatic logic [QUAT_WIDTH-1:0] quat_part(quat_t q, cfg_reg_t r);
		case (r)
			qvr_pkg::REG_QUAT_W: return q.w;
			qvr_pkg::REG_QUAT_X: return q.x;
			qvr_pkg::REG_QUAT_Y: return q.y;
			default:             return q.z;
		endcase
	endfunction

	// Write all four quaternion registers back to back once the block is idle.
	task automatic set_rotation(quat_t q);
		cfg_reg_t r;
		logic [QUAT_WIDTH-1:0] part;
		wait_idle();
		r = qvr_pkg::REG_QUAT_W;
		forever begin
			part = quat_part(q, r);
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= r;
			cfg_ch.data  <= part;
			do
				@(posedge clk);
			while (cfg_ch.ready !== 1'b1);
			case (r)
				qvr_pkg::REG_QUAT_W: cur_quat.w = part;
				qvr_pkg::REG_QUAT_X: cur_quat.x = part;
				qvr_pkg::REG_QUAT_Y: cur_quat.y = part;
				default:             cur_quat.z = part;
			endcase
			if (r == r.last())
				break;
			r = r.next();
		end
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic quat_t make_quat(int w, int x, int y, int z);
		quat_t q;
		q.w = w[QUAT_WIDTH-1:0];
		q.x = x[QUAT_WIDTH-1:0];
		q.y = y[QUAT_WIDTH-1:0];
		q.z = z[QUAT_WIDTH-1:0];
		return q;
	endfunction

	function automatic vertex_t make_vertex(int x, int y, int z);
		vertex_t v;
		v.x = x[COORD_WIDTH-1:0];
		v.y = y[COORD_WIDTH-1:0];
		v.z = z[COORD_WIDTH-1:0];
		return v;
	endfunction

	// Random unit quaternion: a random direction in 4-space scaled to just below 1.0.
	function automatic quat_t random_unit_quat();
		real a, b, c, d, n;
		a = real'(int'($urandom_range(0, 65535)) - 32768);
		b = real'(int'($urandom_range(0, 65535)) - 32768);
		c = real'(int'($urandom_range(0, 65535)) - 32768);
		d = real'(int'($urandom_range(0, 65535)) - 32768);
		n = $sqrt(a * a + b * b + c * c + d * d);
		if (n < 1.0)
			return make_quat(int'(Q_MAX), 0, 0, 0);
		return make_quat($rtoi(a / n * 32767.0), $rtoi(b / n * 32767.0),
			$rtoi(c / n * 32767.0), $rtoi(d / n * 32767.0));
	endfunction

	// Any register value at all, most of them far from unit length.
	function automatic quat_t random_raw_quat();
		return make_quat($urandom_range(0, 65535), $urandom_range(0, 65535),
			$urandom_range(0, 65535), $urandom_range(0, 65535));
	endfunction

	// Mostly full-range coordinates, some extremes and some small values.
	function automatic logic signed [COORD_WIDTH-1:0] random_coord();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 6)
			return COORD_WIDTH'($urandom_range(0, (1 << COORD_WIDTH) - 1));
		if (pick < 8) begin
			case ($urandom_range(0, 4))
				0:       return C_MAX;
				1:       return C_MIN;
				2:       return COORD_WIDTH'(1);
				3:       return COORD_WIDTH'(-1);
				default: return '0;
			endcase
		end
		return COORD_WIDTH'(int'($urandom_range(0, 2000)) - 1000);
	endfunction

	function automatic vertex_t random_vertex();
		vertex_t v;
		v.x = random_coord();
		v.y = random_coord();
		v.z = random_coord();
		return v;
	endfunction

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------

	// The reset quaternion sits just below identity and shrinks each vertex slightly.
	task automatic test_reset_rotation();
		send_vertex(make_vertex(0, 0, 0));
		send_vertex(make_vertex(int'(C_MAX), int'(C_MAX), int'(C_MAX)));
		send_vertex(make_vertex(int'(C_MIN), int'(C_MIN), int'(C_MIN)));
		send_vertex(make_vertex(int'(C_MAX), int'(C_MIN), 1));
		send_vertex(make_vertex(-1, 0, int'(C_MAX)));
	endtask

	// The zero quaternion maps every vertex to the origin.
	task automatic test_zero_rotation();
		set_rotation(make_quat(0, 0, 0, 0));
		send_vertex(make_vertex(int'(C_MAX), int'(C_MIN), int'(C_MAX)));
		send_vertex(make_vertex(12345, -54321, 777));
		send_vertex(make_vertex(int'(C_MIN), 1, -1));
	endtask

	// Register extremes: non-unit quaternions scale by |q|^2 and saturate.
	task automatic test_extreme_quats();
		set_rotation(make_quat(int'(Q_MAX), int'(Q_MAX), int'(Q_MAX), int'(Q_MAX)));
		send_vertex(make_vertex(int'(C_MAX), int'(C_MAX), int'(C_MAX)));
		send_vertex(make_vertex(int'(C_MIN), int'(C_MAX), 0));
		send_vertex(make_vertex(100, -200, 300));
		set_rotation(make_quat(int'(Q_MIN), int'(Q_MIN), int'(Q_MIN), int'(Q_MIN)));
		send_vertex(make_vertex(int'(C_MIN), int'(C_MIN), int'(C_MIN)));
		send_vertex(make_vertex(int'(C_MAX), int'(C_MIN), int'(C_MAX)));
		send_vertex(make_vertex(-3, 5, -7));
		// Exactly -1.0: the two sign flips cancel and the vertex comes back whole.
		set_rotation(make_quat(int'(Q_MIN), 0, 0, 0));
		send_vertex(make_vertex(int'(C_MAX), int'(C_MIN), 1));
		send_vertex(make_vertex(-65536, 65535, -1));
	endtask

	// Quarter turn about z and half turn about x.
	task automatic test_quarter_turns();
		set_rotation(make_quat(23170, 0, 0, 23170));
		send_vertex(make_vertex(100000, 0, 0));
		send_vertex(make_vertex(int'(C_MAX), int'(C_MIN), int'(C_MAX)));
		set_rotation(make_quat(0, int'(Q_MAX), 0, 0));
		send_vertex(make_vertex(0, 100000, -50000));
		send_vertex(make_vertex(int'(C_MIN), int'(C_MAX), int'(C_MIN)));
	endtask

	// Hold off the result side long enough for the pipeline to fill and push back on input.
	task automatic test_backpressure();
		set_rotation(random_unit_quat());
		gaps_on = 1'b0;
		hold_req++;
		repeat (40) send_vertex(random_vertex());
		gaps_on = 1'b1;
	endtask

	// Random vertices under a series of quaternions, most of them unit length.
	task automatic test_random_rotations();
		for (int phase = 0; phase < 8; phase++) begin
			if (phase % 4 == 3)
				set_rotation(random_raw_quat());
			else
				set_rotation(random_unit_quat());
			gaps_on = ($urandom_range(0, 2) != 0);
			repeat (170) send_vertex(random_vertex());
		end
		// Leave the block on the largest register values.
		set_rotation(make_quat(int'(Q_MAX), int'(Q_MAX), int'(Q_MAX), int'(Q_MAX)));
		gaps_on = 1'b1;
		repeat (20) send_vertex(random_vertex());
	endtask

	task automatic finish_run();
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_rotations.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	endtask

	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		burst_left     = 0;
		gaps_on        = 1'b1;
		cur_quat       = make_quat(int'(qvr_pkg::QUAT_W_RESET), int'(qvr_pkg::QUAT_V_RESET),
			int'(qvr_pkg::QUAT_V_RESET), int'(qvr_pkg::QUAT_V_RESET));
		vec_ch.valid   <= 1'b0;
		vec_ch.vec_x   <= '0;
		vec_ch.vec_y   <= '0;
		vec_ch.vec_z   <= '0;
		cfg_ch.valid   <= 1'b0;
		cfg_ch.index   <= qvr_pkg::REG_QUAT_W;
		cfg_ch.data    <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_rotation();
		test_zero_rotation();
		test_extreme_quats();
		test_quarter_turns();
		test_backpressure();
		test_random_rotations();
		finish_run();
	end

endmodule

/* files.f */
rtl/qvr_pkg.sv
rtl/qvr_if.sv
rtl/qvr_regs.sv
rtl/qvr_left.sv
rtl/qvr_right.sv
rtl/quaternion_vector_rotator.sv
dv/tb_quaternion_vector_rotator.sv
